// ===== hw/rtl/blake3_tree_hash_xof_macros.svh =====
// ----------------------------------------------------------------------------
// blake3 tree hash xof assertion macros
// shared concurrent assertion forms, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef BLAKE3_TREE_HASH_XOF_MACROS_SVH
`define BLAKE3_TREE_HASH_XOF_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define B3X_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b3x assertion failed");

// next-cycle implication
`define B3X_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b3x assertion failed");

`else

`define B3X_ASSERT_IMP(lbl, ante, cons)
`define B3X_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/b3x_pkg.sv =====
// ----------------------------------------------------------------------------
// b3x_pkg
// types, constants and control bundles of the blake3 tree hash block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b3x_pkg;

    localparam int CV_W  = 256;
    localparam int BLK_W = 512;

    localparam logic [CV_W-1:0] IV_VEC = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam logic [3:0] PERM [16] = '{
        4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
        4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
    };

    localparam logic [7:0] FL_START  = 8'd1;
    localparam logic [7:0] FL_END    = 8'd2;
    localparam logic [7:0] FL_PARENT = 8'd4;
    localparam logic [7:0] FL_ROOT   = 8'd8;
    localparam logic [7:0] FL_KEYED  = 8'd16;
    localparam logic [7:0] FL_CTX    = 8'd32;
    localparam logic [7:0] FL_MAT    = 8'd64;

    localparam logic [1:0] MODE_HASH  = 2'd0;
    localparam logic [1:0] MODE_KEYED = 2'd1;
    localparam logic [1:0] MODE_CTX   = 2'd2;
    localparam logic [1:0] MODE_MAT   = 2'd3;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_KEY01   = 3'd1,
        REG_KEY23   = 3'd2,
        REG_KEY45   = 3'd3,
        REG_KEY67   = 3'd4,
        REG_SEEK    = 3'd5,
        REG_OUT_LEN = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEL_CHUNK,
        SEL_PARENT,
        SEL_ROOT_CV,
        SEL_ROOT_OUT
    } node_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABSORB,
        S_BLK_WAIT,
        S_FIN_WAIT,
        S_MERGE_CHK,
        S_MERGE_RD,
        S_MERGE_WAIT,
        S_PUSH,
        S_FOLD_LOAD,
        S_FOLD_CHK,
        S_FOLD_WAIT,
        S_OUT_INIT,
        S_OUT_BYTE,
        S_OUT_WAIT,
        S_OUT_SEND,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic      item_load;
        logic      put_byte;
        logic      eng_start;
        node_sel_t eng_sel;
        logic      end_blk;
        logic      blk_done;
        logic      fin_latch;
        logic      stack_rd;
        logic      merge_done;
        logic      push;
        logic      root_load;
        logic      fold_done;
        logic      out_init;
        logic      words_load;
        logic      out_take;
        logic      out_flush;
        logic      msg_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic item_final;
        logic fill_full;
        logic blk_last;
        logic t_even;
        logic sc_zero;
        logic eng_busy;
        logic eng_done;
        logic need_block;
        logic out_end;
        logic word_full;
        logic len_zero;
        logic out_last;
    } ctrl_stat_t;

endpackage

// ===== hw/rtl/b3x_if.sv =====
// ----------------------------------------------------------------------------
// b3x channel interfaces
// message input, digest output and configuration write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface b3x_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        final_item;

    modport source (output valid, output data_word, output byte_count,
                    output final_item, input ready);
    modport sink (input valid, input data_word, input byte_count,
                  input final_item, output ready);
endinterface

interface b3x_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        out_last;
    logic        overflow;

    modport source (output valid, output out_word, output out_bytes,
                    output out_last, output overflow, input ready);
    modport sink (input valid, input out_word, input out_bytes,
                  input out_last, input overflow, output ready);
endinterface

interface b3x_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/b3x_ram.sv =====
// ----------------------------------------------------------------------------
// b3x_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b3x_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 54
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/b3x_compress.sv =====
// ----------------------------------------------------------------------------
// b3x_compress
// iterative compression, four g lanes a quarter step per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b3x_compress (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [b3x_pkg::CV_W-1:0]  h_in,
    input  logic [b3x_pkg::BLK_W-1:0] m_in,
    input  logic [63:0]               ctr_in,
    input  logic [6:0]                len_in,
    input  logic [7:0]                fl_in,
    output logic                      busy,
    output logic                      done,
    output logic [b3x_pkg::BLK_W-1:0] out_blk
);
    logic [31:0]              s_reg [16];
    logic [31:0]              s_next [16];
    logic [31:0]              m_reg [16];
    logic [31:0]              m_next [16];
    logic [b3x_pkg::CV_W-1:0] h_reg;
    logic [5:0]               step_reg;
    logic                     busy_reg;
    logic                     done_reg;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // one quarter of the g function, returns {a, b, c, d}
    function automatic logic [127:0] gsub(input logic [1:0] sub,
                                          input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d,
                                          input logic [31:0] x, input logic [31:0] y);
        logic [31:0] na, nb, nc, nd;
        na = a; nb = b; nc = c; nd = d;
        case (sub)
            2'd0:
            begin
                na = a + b + x;
                nd = rotr(d ^ na, 16);
            end
            2'd1:
            begin
                nc = c + d;
                nb = rotr(b ^ nc, 12);
            end
            2'd2:
            begin
                na = a + b + y;
                nd = rotr(d ^ na, 8);
            end
            default:
            begin
                nc = c + d;
                nb = rotr(b ^ nc, 7);
            end
        endcase
        gsub = {na, nb, nc, nd};
    endfunction

    always_comb
    begin
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            s_next[i] = s_reg[i];
            m_next[i] = m_reg[i];
        end
        for (int j = 0; j < 4; j++)
        begin
            if (!step_reg[2])
            begin
                r = gsub(step_reg[1:0], s_reg[j], s_reg[4+j], s_reg[8+j], s_reg[12+j],
                         m_reg[2*j], m_reg[2*j+1]);
                s_next[j]    = r[127:96];
                s_next[4+j]  = r[95:64];
                s_next[8+j]  = r[63:32];
                s_next[12+j] = r[31:0];
            end
            else
            begin
                r = gsub(step_reg[1:0], s_reg[j], s_reg[4+((j+1)%4)],
                         s_reg[8+((j+2)%4)], s_reg[12+((j+3)%4)],
                         m_reg[8+2*j], m_reg[9+2*j]);
                s_next[j]              = r[127:96];
                s_next[4+((j+1)%4)]    = r[95:64];
                s_next[8+((j+2)%4)]    = r[63:32];
                s_next[12+((j+3)%4)]   = r[31:0];
            end
        end
        // message permutation at the end of each round
        if (step_reg[2:0] == 3'd7)
        begin
            for (int i = 0; i < 16; i++)
            begin
                m_next[i] = m_reg[b3x_pkg::PERM[i]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'd55)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg <= h_in;
            for (int i = 0; i < 8; i++)
            begin
                s_reg[i] <= h_in[32*i +: 32];
            end
            for (int i = 0; i < 4; i++)
            begin
                s_reg[8+i] <= b3x_pkg::IV_VEC[32*i +: 32];
            end
            s_reg[12] <= ctr_in[31:0];
            s_reg[13] <= ctr_in[63:32];
            s_reg[14] <= {25'd0, len_in};
            s_reg[15] <= {24'd0, fl_in};
            for (int i = 0; i < 16; i++)
            begin
                m_reg[i] <= m_in[32*i +: 32];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                s_reg[i] <= s_next[i];
                m_reg[i] <= m_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            out_blk[32*i +: 32]     = s_reg[i] ^ s_reg[i+8];
            out_blk[32*(i+8) +: 32] = s_reg[i+8] ^ h_reg[32*i +: 32];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule

// ===== hw/rtl/b3x_datapath.sv =====
// ----------------------------------------------------------------------------
// b3x_datapath
// config registers, chunk state, subtree stack, root node and output packing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b3x_datapath #(
    parameter int STACK_DEPTH   = 54,
    parameter int MAX_OUT_BYTES = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic [63:0]           in_data,
    input  logic [3:0]            in_count,
    input  logic                  in_final,
    input  b3x_pkg::ctrl_cmd_t    cmd,
    output b3x_pkg::ctrl_stat_t   st,
    output logic [63:0]           out_word,
    output logic [3:0]            out_bytes,
    output logic                  out_last,
    output logic                  overflow
);
    localparam int SC_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int K_W  = $clog2(MAX_OUT_BYTES + 1);

    // configuration
    logic [1:0]                mode_reg;
    logic [b3x_pkg::CV_W-1:0]  key_reg;
    logic [63:0]               seek_reg;
    logic [9:0]                olen_reg;

    // current item
    logic [63:0]               item_data_reg;
    logic [3:0]                item_rem_reg;
    logic                      item_final_reg;

    // chunk and tree state
    logic [b3x_pkg::BLK_W-1:0] buf_reg;
    logic [6:0]                fill_reg;
    logic [3:0]                blk_reg;
    logic [b3x_pkg::CV_W-1:0]  cv_reg;
    logic [63:0]               chunk_reg;
    logic [SC_W-1:0]           sc_reg;
    logic                      ovf_reg;
    logic [b3x_pkg::CV_W-1:0]  tmp_cv_reg;
    logic [63:0]               t_reg;

    // root node
    logic [b3x_pkg::CV_W-1:0]  root_h_reg;
    logic [b3x_pkg::BLK_W-1:0] root_m_reg;
    logic [63:0]               root_ctr_reg;
    logic [6:0]                root_len_reg;
    logic [7:0]                root_fl_reg;

    // output packing
    logic [b3x_pkg::BLK_W-1:0] words_reg;
    logic                      have_reg;
    logic [K_W-1:0]            k_reg;
    logic [63:0]               acc_reg;
    logic [3:0]                accn_reg;
    logic                      last_reg;

    logic [b3x_pkg::CV_W-1:0]  key_vec;
    logic [7:0]                mode_fl;
    logic [b3x_pkg::CV_W-1:0]  chunk_h;
    logic [7:0]                chunk_fl;
    logic [63:0]               pos;
    logic [K_W-1:0]            len_eff;
    logic [K_W:0]              k_plus;
    logic [7:0]                out_byte;
    logic [SC_W-1:0]           sc_dec;
    logic                      sc_full;

    logic [b3x_pkg::CV_W-1:0]  eng_h;
    logic [b3x_pkg::BLK_W-1:0] eng_m;
    logic [63:0]               eng_ctr;
    logic [6:0]                eng_len;
    logic [7:0]                eng_fl;
    logic                      eng_busy;
    logic                      eng_done;
    logic [b3x_pkg::BLK_W-1:0] eng_out;
    logic [b3x_pkg::CV_W-1:0]  ram_q;

    always_comb
    begin
        key_vec = mode_reg[0] ? key_reg : b3x_pkg::IV_VEC;
        case (mode_reg)
            b3x_pkg::MODE_HASH:  mode_fl = 8'd0;
            b3x_pkg::MODE_KEYED: mode_fl = b3x_pkg::FL_KEYED;
            b3x_pkg::MODE_CTX:   mode_fl = b3x_pkg::FL_CTX;
            b3x_pkg::MODE_MAT:   mode_fl = b3x_pkg::FL_MAT;
            default:             mode_fl = 8'd0;
        endcase
        chunk_h  = (blk_reg == 4'd0) ? key_vec : cv_reg;
        chunk_fl = mode_fl | ((blk_reg == 4'd0) ? b3x_pkg::FL_START : 8'd0);
        pos      = seek_reg + {{(64-K_W){1'b0}}, k_reg};
        len_eff  = ({1'b0, olen_reg} > 11'(MAX_OUT_BYTES)) ? K_W'(MAX_OUT_BYTES)
                                                           : K_W'(olen_reg);
        k_plus   = {1'b0, k_reg} + {{K_W{1'b0}}, 1'b1};
        out_byte = words_reg[8*pos[5:0] +: 8];
        sc_dec   = sc_reg - {{(SC_W-1){1'b0}}, 1'b1};
        sc_full  = (sc_reg == SC_W'(STACK_DEPTH));
    end

    // engine operand select
    always_comb
    begin
        case (cmd.eng_sel)
            b3x_pkg::SEL_CHUNK:
            begin
                eng_h   = chunk_h;
                eng_m   = buf_reg;
                eng_ctr = chunk_reg;
                eng_len = fill_reg;
                eng_fl  = chunk_fl | (cmd.end_blk ? b3x_pkg::FL_END : 8'd0);
            end
            b3x_pkg::SEL_PARENT:
            begin
                eng_h   = key_vec;
                eng_m   = {tmp_cv_reg, ram_q};
                eng_ctr = 64'd0;
                eng_len = 7'd64;
                eng_fl  = mode_fl | b3x_pkg::FL_PARENT;
            end
            b3x_pkg::SEL_ROOT_CV:
            begin
                eng_h   = root_h_reg;
                eng_m   = root_m_reg;
                eng_ctr = root_ctr_reg;
                eng_len = root_len_reg;
                eng_fl  = root_fl_reg;
            end
            default:
            begin
                eng_h   = root_h_reg;
                eng_m   = root_m_reg;
                eng_ctr = {6'd0, pos[63:6]};
                eng_len = root_len_reg;
                eng_fl  = root_fl_reg | b3x_pkg::FL_ROOT;
            end
        endcase
    end

    b3x_compress u_compress (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.eng_start),
        .h_in    (eng_h),
        .m_in    (eng_m),
        .ctr_in  (eng_ctr),
        .len_in  (eng_len),
        .fl_in   (eng_fl),
        .busy    (eng_busy),
        .done    (eng_done),
        .out_blk (eng_out)
    );

    b3x_ram #(
        .WIDTH (b3x_pkg::CV_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push && !sc_full),
        .waddr (sc_reg[SA_W-1:0]),
        .wdata (tmp_cv_reg),
        .re    (cmd.stack_rd),
        .raddr (sc_dec[SA_W-1:0]),
        .rdata (ram_q)
    );

    // control-side state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= b3x_pkg::MODE_HASH;
            key_reg      <= '0;
            seek_reg     <= '0;
            olen_reg     <= 10'd32;
            item_rem_reg <= '0;
            buf_reg      <= '0;
            fill_reg     <= '0;
            blk_reg      <= '0;
            chunk_reg    <= '0;
            sc_reg       <= '0;
            ovf_reg      <= 1'b0;
            have_reg     <= 1'b0;
            k_reg        <= '0;
            accn_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    b3x_pkg::REG_MODE:    mode_reg           <= cfg_data[1:0];
                    b3x_pkg::REG_KEY01:   key_reg[63:0]      <= cfg_data;
                    b3x_pkg::REG_KEY23:   key_reg[127:64]    <= cfg_data;
                    b3x_pkg::REG_KEY45:   key_reg[191:128]   <= cfg_data;
                    b3x_pkg::REG_KEY67:   key_reg[255:192]   <= cfg_data;
                    b3x_pkg::REG_SEEK:    seek_reg           <= cfg_data;
                    b3x_pkg::REG_OUT_LEN: olen_reg           <= cfg_data[9:0];
                    default:              ;
                endcase
            end

            if (cmd.item_load)
            begin
                item_rem_reg <= (in_count > 4'd8) ? 4'd8 : in_count;
            end
            if (cmd.put_byte)
            begin
                item_rem_reg                  <= item_rem_reg - 4'd1;
                buf_reg[8*fill_reg[5:0] +: 8] <= item_data_reg[7:0];
                fill_reg                      <= fill_reg + 7'd1;
            end
            if (cmd.blk_done)
            begin
                blk_reg  <= blk_reg + 4'd1;
                fill_reg <= '0;
                buf_reg  <= '0;
            end
            if (cmd.stack_rd)
            begin
                sc_reg <= sc_dec;
            end
            if (cmd.push)
            begin
                if (sc_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    sc_reg <= sc_reg + {{(SC_W-1){1'b0}}, 1'b1};
                end
                chunk_reg <= chunk_reg + 64'd1;
                fill_reg  <= '0;
                blk_reg   <= '0;
                buf_reg   <= '0;
            end
            if (cmd.msg_clear)
            begin
                fill_reg  <= '0;
                blk_reg   <= '0;
                buf_reg   <= '0;
                chunk_reg <= '0;
                sc_reg    <= '0;
                ovf_reg   <= 1'b0;
            end

            if (cmd.out_init)
            begin
                have_reg <= 1'b0;
                k_reg    <= '0;
                accn_reg <= '0;
            end
            if (cmd.words_load)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.out_take)
            begin
                // crossing into the next 64-byte output block needs a new compression
                have_reg <= (pos[5:0] != 6'd63);
                k_reg    <= k_plus[K_W-1:0];
                accn_reg <= accn_reg + 4'd1;
            end
            if (cmd.out_flush)
            begin
                accn_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_data_reg  <= in_data;
            item_final_reg <= in_final;
        end
        if (cmd.put_byte)
        begin
            item_data_reg <= {8'd0, item_data_reg[63:8]};
        end
        if (cmd.blk_done)
        begin
            cv_reg <= eng_out[b3x_pkg::CV_W-1:0];
        end
        if (cmd.fin_latch)
        begin
            tmp_cv_reg <= eng_out[b3x_pkg::CV_W-1:0];
            t_reg      <= chunk_reg + 64'd1;
        end
        if (cmd.merge_done)
        begin
            tmp_cv_reg <= eng_out[b3x_pkg::CV_W-1:0];
            t_reg      <= {1'b0, t_reg[63:1]};
        end
        if (cmd.root_load)
        begin
            root_h_reg   <= chunk_h;
            root_m_reg   <= buf_reg;
            root_ctr_reg <= chunk_reg;
            root_len_reg <= fill_reg;
            root_fl_reg  <= chunk_fl | b3x_pkg::FL_END;
        end
        if (cmd.fold_done)
        begin
            root_h_reg   <= key_vec;
            root_m_reg   <= {eng_out[b3x_pkg::CV_W-1:0], ram_q};
            root_ctr_reg <= 64'd0;
            root_len_reg <= 7'd64;
            root_fl_reg  <= mode_fl | b3x_pkg::FL_PARENT;
        end
        if (cmd.words_load)
        begin
            words_reg <= eng_out;
        end
        if (cmd.out_init || cmd.out_flush)
        begin
            acc_reg <= '0;
        end
        if (cmd.out_take)
        begin
            acc_reg[8*accn_reg[2:0] +: 8] <= out_byte;
            last_reg                      <= (k_plus == {1'b0, len_eff});
        end
    end

    always_comb
    begin
        st.rem_zero   = (item_rem_reg == 4'd0);
        st.item_final = item_final_reg;
        st.fill_full  = (fill_reg == 7'd64);
        st.blk_last   = (blk_reg == 4'd15);
        st.t_even     = !t_reg[0];
        st.sc_zero    = (sc_reg == '0);
        st.eng_busy   = eng_busy;
        st.eng_done   = eng_done;
        st.need_block = !have_reg;
        st.out_end    = (k_plus == {1'b0, len_eff});
        st.word_full  = (accn_reg == 4'd7);
        st.len_zero   = (len_eff == '0);
        st.out_last   = last_reg;
    end

    assign out_word  = acc_reg;
    assign out_bytes = accn_reg;
    assign out_last  = last_reg;
    assign overflow  = ovf_reg;
endmodule

// ===== hw/rtl/b3x_ctrl.sv =====
// ----------------------------------------------------------------------------
// b3x_ctrl
// sequencer for absorb, chunk merge, root fold and output phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "blake3_tree_hash_xof_macros.svh"

module b3x_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  b3x_pkg::ctrl_stat_t st,
    output b3x_pkg::ctrl_cmd_t  cmd
);
    b3x_pkg::state_t state_reg;
    b3x_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b3x_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            b3x_pkg::S_IDLE:
                if (in_valid) state_next = b3x_pkg::S_ABSORB;
            b3x_pkg::S_ABSORB:
                if (st.rem_zero)
                    state_next = st.item_final ? b3x_pkg::S_FOLD_LOAD : b3x_pkg::S_IDLE;
                else if (st.fill_full)
                    state_next = st.blk_last ? b3x_pkg::S_FIN_WAIT : b3x_pkg::S_BLK_WAIT;
            b3x_pkg::S_BLK_WAIT:
                if (st.eng_done) state_next = b3x_pkg::S_ABSORB;
            b3x_pkg::S_FIN_WAIT:
                if (st.eng_done) state_next = b3x_pkg::S_MERGE_CHK;
            b3x_pkg::S_MERGE_CHK:
                state_next = (st.t_even && !st.sc_zero) ? b3x_pkg::S_MERGE_RD
                                                        : b3x_pkg::S_PUSH;
            b3x_pkg::S_MERGE_RD:
                state_next = b3x_pkg::S_MERGE_WAIT;
            b3x_pkg::S_MERGE_WAIT:
                if (st.eng_done) state_next = b3x_pkg::S_MERGE_CHK;
            b3x_pkg::S_PUSH:
                state_next = b3x_pkg::S_ABSORB;
            b3x_pkg::S_FOLD_LOAD:
                state_next = b3x_pkg::S_FOLD_CHK;
            b3x_pkg::S_FOLD_CHK:
                state_next = st.sc_zero ? b3x_pkg::S_OUT_INIT : b3x_pkg::S_FOLD_WAIT;
            b3x_pkg::S_FOLD_WAIT:
                if (st.eng_done) state_next = b3x_pkg::S_FOLD_CHK;
            b3x_pkg::S_OUT_INIT:
                state_next = st.len_zero ? b3x_pkg::S_CLEAR : b3x_pkg::S_OUT_BYTE;
            b3x_pkg::S_OUT_BYTE:
                if (st.need_block)
                    state_next = b3x_pkg::S_OUT_WAIT;
                else if (st.out_end || st.word_full)
                    state_next = b3x_pkg::S_OUT_SEND;
            b3x_pkg::S_OUT_WAIT:
                if (st.eng_done) state_next = b3x_pkg::S_OUT_BYTE;
            b3x_pkg::S_OUT_SEND:
                if (out_ready)
                    state_next = st.out_last ? b3x_pkg::S_CLEAR : b3x_pkg::S_OUT_BYTE;
            b3x_pkg::S_CLEAR:
                state_next = b3x_pkg::S_IDLE;
            default:
                state_next = b3x_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.eng_sel = b3x_pkg::SEL_CHUNK;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            b3x_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.item_load = in_valid;
            end
            b3x_pkg::S_ABSORB:
                if (!st.rem_zero)
                begin
                    if (st.fill_full)
                    begin
                        cmd.eng_start = 1'b1;
                        cmd.end_blk   = st.blk_last;
                    end
                    else
                    begin
                        cmd.put_byte = 1'b1;
                    end
                end
            b3x_pkg::S_BLK_WAIT:
                cmd.blk_done = st.eng_done;
            b3x_pkg::S_FIN_WAIT:
                cmd.fin_latch = st.eng_done;
            b3x_pkg::S_MERGE_CHK:
                cmd.stack_rd = st.t_even && !st.sc_zero;
            b3x_pkg::S_MERGE_RD:
            begin
                cmd.eng_start = 1'b1;
                cmd.eng_sel   = b3x_pkg::SEL_PARENT;
            end
            b3x_pkg::S_MERGE_WAIT:
                cmd.merge_done = st.eng_done;
            b3x_pkg::S_PUSH:
                cmd.push = 1'b1;
            b3x_pkg::S_FOLD_LOAD:
                cmd.root_load = 1'b1;
            b3x_pkg::S_FOLD_CHK:
                if (!st.sc_zero)
                begin
                    cmd.stack_rd  = 1'b1;
                    cmd.eng_start = 1'b1;
                    cmd.eng_sel   = b3x_pkg::SEL_ROOT_CV;
                end
            b3x_pkg::S_FOLD_WAIT:
                cmd.fold_done = st.eng_done;
            b3x_pkg::S_OUT_INIT:
                cmd.out_init = 1'b1;
            b3x_pkg::S_OUT_BYTE:
            begin
                cmd.eng_sel = b3x_pkg::SEL_ROOT_OUT;
                if (st.need_block)
                    cmd.eng_start = 1'b1;
                else
                    cmd.out_take = 1'b1;
            end
            b3x_pkg::S_OUT_WAIT:
            begin
                cmd.eng_sel    = b3x_pkg::SEL_ROOT_OUT;
                cmd.words_load = st.eng_done;
            end
            b3x_pkg::S_OUT_SEND:
            begin
                out_valid     = 1'b1;
                cmd.out_flush = out_ready && !st.out_last;
            end
            b3x_pkg::S_CLEAR:
                cmd.msg_clear = 1'b1;
            default:
                ;
        endcase
    end

    `B3X_ASSERT_IMP(a_hs_excl, in_ready, !out_valid)
    `B3X_ASSERT_IMP(a_start_idle, cmd.eng_start, !st.eng_busy)
    `B3X_ASSERT_IMP(a_pop_nonempty, cmd.stack_rd, !st.sc_zero)
    `B3X_ASSERT_NEXT(a_last_clears, out_valid && out_ready && st.out_last, state_reg == b3x_pkg::S_CLEAR)
    `B3X_ASSERT_IMP(a_done_waited, st.eng_done, state_reg == b3x_pkg::S_BLK_WAIT || state_reg == b3x_pkg::S_FIN_WAIT || state_reg == b3x_pkg::S_MERGE_WAIT || state_reg == b3x_pkg::S_FOLD_WAIT || state_reg == b3x_pkg::S_OUT_WAIT)
endmodule

// ===== hw/rtl/blake3_tree_hash_xof.sv =====
// flow: each message item is accepted in idle, then its bytes are absorbed one at a time; each
//   full 64-byte block is compressed, and each tree merge runs, on the one shared compression unit
// throughput: one item at a time; a new item is accepted only after the last one is absorbed
// finalization: each stacked subtree is folded into the root and each 64-byte output block is
//   compressed, then output bytes are packed into words, with one handshake per output word
// reset: asynchronous active low, registers to defaults, message state empty, no clearing pass
// ----------------------------------------------------------------------------
// blake3_tree_hash_xof
// blake3 hasher with chunk tree, four modes and seekable extendable output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blake3_tree_hash_xof #(
    parameter int STACK_DEPTH   = 54,
    parameter int MAX_OUT_BYTES = 512
) (
    input  logic      clk,
    input  logic      rst_n,
    b3x_msg_if.sink   msg_in,
    b3x_out_if.source digest_out,
    b3x_cfg_if.sink   cfg
);
    // command and status bundle between sequencer and datapath
    b3x_pkg::ctrl_cmd_t  cmd;
    b3x_pkg::ctrl_stat_t st;

    // configuration writes are registered directly, the port never stalls
    assign cfg.ready = 1'b1;

    // sequencer: absorbs bytes, drives chunk merges, root fold and output packing
    b3x_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg_in.valid),
        .in_ready  (msg_in.ready),
        .out_valid (digest_out.valid),
        .out_ready (digest_out.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: config registers, block buffer, subtree stack ram, compression unit
    b3x_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .MAX_OUT_BYTES (MAX_OUT_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_data   (msg_in.data_word),
        .in_count  (msg_in.byte_count),
        .in_final  (msg_in.final_item),
        .cmd       (cmd),
        .st        (st),
        .out_word  (digest_out.out_word),
        .out_bytes (digest_out.out_bytes),
        .out_last  (digest_out.out_last),
        .overflow  (digest_out.overflow)
    );
endmodule

// ===== tb/tb_blake3_tree_hash_xof.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blake3_tree_hash_xof
// self-checking bench: random message streams in all four modes, checked
// word by word against an in-bench blake3 tree and xof predictor
// ----------------------------------------------------------------------------

module tb_blake3_tree_hash_xof;

    typedef bit [31:0] w8_t [8];
    typedef bit [31:0] w16_t [16];

    typedef struct {
        w8_t       h;
        w16_t      m;
        bit [63:0] ctr;
        bit [31:0] len;
        bit [31:0] fl;
    } hnode_t;

    typedef struct {
        bit [63:0] word;
        bit [3:0]  nbytes;
        bit        last;
        bit        ovf;
    } digest_word_t;

    // ------------------------------------------------------------------------
    // scoreboard: blake3 predictor plus queue of pending digest words
    // ------------------------------------------------------------------------
    class digest_scoreboard;
        bit [1:0]  mode;
        bit [63:0] key [4];
        bit [63:0] seek;
        bit [9:0]  out_len;

        w8_t       cv;
        bit [7:0]  blk [64];
        int        fill;
        int        blocks;
        bit [63:0] chunk_cnt;
        w8_t       stack [54];
        int        depth;
        bit        ovf;

        digest_word_t pending_q [$];
        int           errors;

        function new();
            mode    = b3x_pkg::MODE_HASH;
            foreach (key[i]) key[i] = '0;
            seek    = '0;
            out_len = 10'd32;
            errors  = 0;
            clear_msg();
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void mix(inout w16_t s, input int a, int b, int c, int d,
                          input bit [31:0] x, bit [31:0] y);
            s[a] = s[a] + s[b] + x; s[d] = rotr(s[d] ^ s[a], 16);
            s[c] = s[c] + s[d];     s[b] = rotr(s[b] ^ s[c], 12);
            s[a] = s[a] + s[b] + y; s[d] = rotr(s[d] ^ s[a], 8);
            s[c] = s[c] + s[d];     s[b] = rotr(s[b] ^ s[c], 7);
        endfunction

        function void compress(input hnode_t n, input bit [63:0] ctr,
                               input bit [31:0] fl, output w16_t o);
            w16_t s;
            w16_t m;
            w16_t t;
            for (int i = 0; i < 8; i++)
            begin
                s[i]     = n.h[i];
                s[i + 8] = b3x_pkg::IV_VEC[32*i +: 32];
            end
            s[12] = ctr[31:0];
            s[13] = ctr[63:32];
            s[14] = n.len;
            s[15] = fl;
            m = n.m;
            for (int r = 0; r < 7; r++)
            begin
                mix(s, 0, 4, 8, 12, m[0], m[1]);   mix(s, 1, 5, 9, 13, m[2], m[3]);
                mix(s, 2, 6, 10, 14, m[4], m[5]);  mix(s, 3, 7, 11, 15, m[6], m[7]);
                mix(s, 0, 5, 10, 15, m[8], m[9]);  mix(s, 1, 6, 11, 12, m[10], m[11]);
                mix(s, 2, 7, 8, 13, m[12], m[13]); mix(s, 3, 4, 9, 14, m[14], m[15]);
                for (int i = 0; i < 16; i++) t[i] = m[b3x_pkg::PERM[i]];
                m = t;
            end
            for (int i = 0; i < 8; i++)
            begin
                o[i]     = s[i] ^ s[i + 8];
                o[i + 8] = s[i + 8] ^ n.h[i];
            end
        endfunction

        function w8_t chain_of(hnode_t n);
            w16_t o;
            w8_t  c;
            compress(n, n.ctr, n.fl, o);
            for (int i = 0; i < 8; i++) c[i] = o[i];
            return c;
        endfunction

        function w8_t mode_key();
            w8_t k;
            for (int i = 0; i < 4; i++)
            begin
                k[2*i]     = mode[0] ? key[i][31:0]  : b3x_pkg::IV_VEC[64*i +: 32];
                k[2*i + 1] = mode[0] ? key[i][63:32] : b3x_pkg::IV_VEC[64*i + 32 +: 32];
            end
            return k;
        endfunction

        function bit [31:0] mode_flag();
            case (mode)
                b3x_pkg::MODE_KEYED: return 32'(b3x_pkg::FL_KEYED);
                b3x_pkg::MODE_CTX:   return 32'(b3x_pkg::FL_CTX);
                b3x_pkg::MODE_MAT:   return 32'(b3x_pkg::FL_MAT);
                default:             return 32'd0;
            endcase
        endfunction

        function hnode_t chunk_node(bit [31:0] extra);
            hnode_t n;
            n.h = (blocks == 0) ? mode_key() : cv;
            for (int i = 0; i < 16; i++)
                n.m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            n.ctr = chunk_cnt;
            n.len = 32'(fill);
            n.fl  = mode_flag() | ((blocks == 0) ? 32'(b3x_pkg::FL_START) : 32'd0) | extra;
            return n;
        endfunction

        function hnode_t parent_node(w8_t left, w8_t right);
            hnode_t n;
            n.h = mode_key();
            for (int i = 0; i < 8; i++)
            begin
                n.m[i]     = left[i];
                n.m[i + 8] = right[i];
            end
            n.ctr = 64'd0;
            n.len = 32'd64;
            n.fl  = mode_flag() | 32'(b3x_pkg::FL_PARENT);
            return n;
        endfunction

        function void clear_chunk();
            foreach (cv[i]) cv[i] = '0;
            foreach (blk[i]) blk[i] = '0;
            fill   = 0;
            blocks = 0;
        endfunction

        function void clear_msg();
            clear_chunk();
            chunk_cnt = '0;
            depth     = 0;
            ovf       = 0;
        endfunction

        // close a chunk and carry it up the subtree stack
        function void close_chunk();
            bit [63:0] total;
            w8_t       c;
            total = chunk_cnt + 64'd1;
            c = chain_of(chunk_node(32'(b3x_pkg::FL_END)));
            while (total[0] == 1'b0 && depth > 0)
            begin
                depth--;
                c = chain_of(parent_node(stack[depth], c));
                total = total >> 1;
            end
            if (depth < 54)
            begin
                stack[depth] = c;
                depth++;
            end
            else
                ovf = 1;
            chunk_cnt++;
            clear_chunk();
        endfunction

        function void take_byte(bit [7:0] b);
            hnode_t n;
            w16_t   o;
            if (blocks == 15 && fill == 64) close_chunk();
            if (fill >= 64)
            begin
                n = chunk_node(32'd0);
                compress(n, n.ctr, n.fl, o);
                for (int i = 0; i < 8; i++) cv[i] = o[i];
                blocks++;
                fill = 0;
                foreach (blk[i]) blk[i] = '0;
            end
            blk[fill & 63] = b;
            fill++;
        endfunction

        function void set_reg(b3x_pkg::cfg_reg_t idx, bit [63:0] val);
            case (idx)
                b3x_pkg::REG_MODE:    mode    = val[1:0];
                b3x_pkg::REG_KEY01:   key[0]  = val;
                b3x_pkg::REG_KEY23:   key[1]  = val;
                b3x_pkg::REG_KEY45:   key[2]  = val;
                b3x_pkg::REG_KEY67:   key[3]  = val;
                b3x_pkg::REG_SEEK:    seek    = val;
                b3x_pkg::REG_OUT_LEN: out_len = val[9:0];
                default: ;
            endcase
        endfunction

        // accepted message request: absorb, and on the final one queue the digest
        function void note_request(bit [63:0] data, bit [3:0] cnt, bit fin);
            int           n;
            int           len;
            hnode_t       root;
            w16_t         words;
            bit [63:0]    cached;
            bit           have;
            bit [63:0]    acc;
            int           accn;
            bit [63:0]    pos;
            bit [31:0]    w;
            digest_word_t d;
            n = (cnt > 8) ? 8 : int'(cnt);
            for (int i = 0; i < n; i++) take_byte(data[8*i +: 8]);
            if (!fin) return;
            root = chunk_node(32'(b3x_pkg::FL_END));
            for (int i = depth; i > 0; i--)
                root = parent_node(stack[i - 1], chain_of(root));
            len  = (out_len > 512) ? 512 : int'(out_len);
            have = 0;
            acc  = '0;
            accn = 0;
            cached = '0;
            for (int k = 0; k < len; k++)
            begin
                pos = seek + 64'(k);
                if (!have || {6'd0, pos[63:6]} != cached)
                begin
                    compress(root, {6'd0, pos[63:6]}, root.fl | 32'(b3x_pkg::FL_ROOT), words);
                    cached = {6'd0, pos[63:6]};
                    have   = 1;
                end
                w = words[pos[5:2]];
                acc[8*accn +: 8] = w[8*pos[1:0] +: 8];
                accn++;
                if (accn == 8 || k + 1 == len)
                begin
                    d.word   = acc;
                    d.nbytes = 4'(accn);
                    d.last   = (k + 1 == len);
                    d.ovf    = ovf;
                    pending_q.push_back(d);
                    acc  = '0;
                    accn = 0;
                end
            end
            clear_msg();
        endfunction

        function void check_word(bit [63:0] word, bit [3:0] nbytes, bit last, bit ov);
            digest_word_t d;
            if (pending_q.size() == 0)
            begin
                $error("digest word %h with none expected", word);
                errors++;
                return;
            end
            d = pending_q.pop_front();
            if (word !== d.word)
            begin
                $error("out_word expected %h got %h", d.word, word);
                errors++;
            end
            if (nbytes !== d.nbytes)
            begin
                $error("out_bytes expected %0d got %0d", d.nbytes, nbytes);
                errors++;
            end
            if (last !== d.last)
            begin
                $error("out_last expected %0d got %0d", d.last, last);
                errors++;
            end
            if (ov !== d.ovf)
            begin
                $error("overflow expected %0d got %0d", d.ovf, ov);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    b3x_msg_if msg_ch ();
    b3x_out_if out_ch ();
    b3x_cfg_if cfg_ch ();

    blake3_tree_hash_xof u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_ch),
        .digest_out (out_ch),
        .cfg        (cfg_ch)
    );

    digest_scoreboard sb;
    int  sent_items;
    bit  no_gaps;   // stretches with the sender never idling
    int  stall_left;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random back-pressure on the digest channel
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap();
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // monitor: every accepted digest word is checked in order
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.out_word, out_ch.out_bytes, out_ch.out_last, out_ch.overflow);
    end

    // one message request; valid stays high when no gap follows
    task automatic send_request(bit [63:0] data, bit [3:0] cnt, bit fin);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.data_word  <= data;
        msg_ch.byte_count <= cnt;
        msg_ch.final_item <= fin;
        do @(posedge clk); while (!msg_ch.ready);
        sb.note_request(data, cnt, fin);
        sent_items++;
    endtask

    // drain every pending digest word, then let the block settle
    task automatic wait_idle();
        msg_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // config write, only issued while the block is idle
    task automatic write_reg(b3x_pkg::cfg_reg_t idx, bit [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // message of nbytes bytes, mostly eight per request, last request final
    task automatic send_message(int nbytes);
        int left;
        int c;
        left = nbytes;
        while (left > 8)
        begin
            c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 8;
            send_request({$urandom, $urandom}, 4'(c), 1'b0);
            left -= (c > 8) ? 8 : c;
        end
        send_request({$urandom, $urandom}, 4'(left), 1'b1);
    endtask

    task automatic random_config();
        int r;
        write_reg(b3x_pkg::REG_MODE, 64'($urandom_range(0, 3)));
        r = $urandom_range(0, 3);
        write_reg(b3x_pkg::REG_KEY01, r == 0 ? 64'd0 : r == 1 ? '1 : {$urandom, $urandom});
        write_reg(b3x_pkg::REG_KEY23, {$urandom, $urandom});
        write_reg(b3x_pkg::REG_KEY45, {$urandom, $urandom});
        write_reg(b3x_pkg::REG_KEY67, r == 1 ? '1 : {$urandom, $urandom});
        r = $urandom_range(0, 3);
        write_reg(b3x_pkg::REG_SEEK,
                  r == 0 ? 64'd0 : r == 1 ? 64'd0 - 64'($urandom_range(1, 100)) :
                  r == 2 ? {$urandom, $urandom} : 64'($urandom_range(0, 300)));
        r = $urandom_range(0, 9);
        write_reg(b3x_pkg::REG_OUT_LEN, r == 0 ? 64'd512 : r == 1 ? 64'd1 :
                                        r == 2 ? 64'($urandom_range(513, 1023)) :
                                        64'($urandom_range(1, 80)));
    endtask

    initial
    begin
        sb = new();
        sent_items = 0;
        no_gaps    = 0;
        stall_left = 0;
        rst_n = 1'b0;
        msg_ch.valid = 1'b0;
        msg_ch.data_word = '0;
        msg_ch.byte_count = '0;
        msg_ch.final_item = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = b3x_pkg::REG_MODE;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: empty message, one byte, a full word, oversized count
        send_request('1, 4'd0, 1'b1);
        send_request(64'h0000_0000_0000_00A5, 4'd1, 1'b1);
        send_request('1, 4'd8, 1'b0);
        send_request({$urandom, $urandom}, 4'd15, 1'b1);
        wait_idle();

        // material mode, all-ones key, seek wrapping past 2^64, saturated length
        write_reg(b3x_pkg::REG_MODE, 64'(b3x_pkg::MODE_MAT));
        write_reg(b3x_pkg::REG_KEY01, '1);
        write_reg(b3x_pkg::REG_KEY23, '1);
        write_reg(b3x_pkg::REG_KEY45, '1);
        write_reg(b3x_pkg::REG_KEY67, '1);
        write_reg(b3x_pkg::REG_SEEK, 64'hFFFF_FFFF_FFFF_FFF3);
        write_reg(b3x_pkg::REG_OUT_LEN, 64'd1023);
        for (int i = 0; i < 8; i++) send_request({$urandom, $urandom}, 4'd8, i == 7);
        wait_idle();

        // zero output length: no digest words, message state still cleared
        write_reg(b3x_pkg::REG_OUT_LEN, 64'd0);
        send_request({$urandom, $urandom}, 4'd5, 1'b1);
        wait_idle();

        // keyed with the low key word zeroed, block boundary plus one byte
        write_reg(b3x_pkg::REG_MODE, 64'(b3x_pkg::MODE_KEYED));
        write_reg(b3x_pkg::REG_KEY01, 64'd0);
        write_reg(b3x_pkg::REG_SEEK, 64'd0);
        write_reg(b3x_pkg::REG_OUT_LEN, 64'd33);
        for (int i = 0; i < 8; i++) send_request({$urandom, $urandom}, 4'd8, 1'b0);
        send_request('0, 4'd1, 1'b1);
        wait_idle();
        write_reg(b3x_pkg::REG_MODE, 64'(b3x_pkg::MODE_CTX));
        send_request({$urandom, $urandom}, 4'd7, 1'b1);
        wait_idle();

        // two-chunk message exercises a stack push and a folded root
        no_gaps = 1;
        send_message(1100);
        no_gaps = 0;
        wait_idle();

        // random phases of messages, mostly short
        while (sent_items < 200)
        begin
            random_config();
            repeat ($urandom_range(2, 6))
            begin
                no_gaps = ($urandom_range(0, 4) == 0);
                send_message($urandom_range(0, 3) == 0 ? $urandom_range(65, 300)
                                                       : $urandom_range(0, 64));
            end
            wait_idle();
        end

        wait_idle();
        if (sb.errors == 0)
            $display("tb_blake3_tree_hash_xof passed");
        else
            $display("tb_blake3_tree_hash_xof failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_blake3_tree_hash_xof failed");
        $finish;
    end

endmodule

// ===== blake3_tree_hash_xof.f =====
+incdir+hw/rtl
hw/rtl/b3x_pkg.sv
hw/rtl/b3x_if.sv
hw/rtl/b3x_ram.sv
hw/rtl/b3x_compress.sv
hw/rtl/b3x_datapath.sv
hw/rtl/b3x_ctrl.sv
hw/rtl/blake3_tree_hash_xof.sv
tb/tb_blake3_tree_hash_xof.sv
